### rtl/pet_pkg.sv
// Shared types and codes for the periodic event timer table.
// Used by pet_cell and periodic_event_timer_table_core; no dependencies.
`default_nettype none

package pet_pkg;

	// Largest table and the slot index width that covers it
	localparam int MAX_SLOTS  = 16;
	localparam int IDX_W      = 4;
	localparam int PERIOD_W   = 24;
	localparam int COUNT_W    = 16;

	// Operation codes of an input beat
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_ADD    = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	// Result kinds
	localparam logic [1:0] KIND_FIRED = 2'd0;
	localparam logic [1:0] KIND_ADDED = 2'd1;
	localparam logic [1:0] KIND_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]          operation;
		logic [PERIOD_W-1:0] period;
		logic [COUNT_W-1:0]  repeat_count;
		logic [IDX_W-1:0]    slot;
	} item_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [IDX_W-1:0] slot_index;
		logic             last;
	} result_t;

	// Command broadcast to every cell while the token walks the row
	typedef struct packed {
		logic                tick;
		logic                add;
		logic [PERIOD_W-1:0] period;
		logic [COUNT_W-1:0]  repeat_count;
	} cell_cmd_t;

endpackage

`default_nettype wire

### rtl/pet_cell.sv
// One timer slot of the row: holds its countdown, period and repeat count,
// acts when the scan token reaches it and hands the token on. Uses pet_pkg.
`default_nettype none

module pet_cell (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pet_pkg::cell_cmd_t ctl,
	input  wire logic              tok_in,
	input  wire logic              del,
	output logic                   tok_out,
	output logic                   hit
);

	logic                            used_q;
	logic                            tok_q;
	logic [pet_pkg::PERIOD_W-1:0]    ticks_q;
	logic [pet_pkg::PERIOD_W-1:0]    period_q;
	logic [pet_pkg::COUNT_W-1:0]     firings_q;
	logic                            limited_q;

	logic [pet_pkg::PERIOD_W-1:0]    ticks_dec;
	logic [pet_pkg::COUNT_W-1:0]     firings_dec;
	logic                            claim;
	logic                            fire;
	logic                            done;

	// Lower the countdown with a floor at zero, then check for due
	always_comb begin
		ticks_dec   = (ticks_q == '0) ? '0 : ticks_q - 1'b1;
		firings_dec = firings_q - 1'b1;
		claim       = tok_in && ctl.add && !used_q;
		fire        = tok_in && ctl.tick && used_q && (ticks_dec == '0);
		done        = (period_q == '0) || (limited_q && (firings_dec == '0));
		hit         = claim || fire;
	end

	assign tok_out = tok_q;

	// Hold occupancy and pass the token; an add stops at the claiming cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			tok_q <= tok_in && !claim;
			if (del) begin
				used_q <= 1'b0;
			end else if (claim) begin
				used_q <= 1'b1;
			end else if (fire && done) begin
				used_q <= 1'b0;
			end
		end
	end

	// Slot payload: load on claim, count down or reload on tick
	always_ff @(posedge clk) begin
		if (claim) begin
			period_q  <= ctl.period;
			firings_q <= ctl.repeat_count;
			limited_q <= (ctl.repeat_count != '0);
			ticks_q   <= '0;
		end else if (fire) begin
			if (limited_q) begin
				firings_q <= firings_dec;
			end
			ticks_q <= period_q;
		end else if (tok_in && ctl.tick && used_q) begin
			ticks_q <= ticks_dec;
		end
	end

endmodule

`default_nettype wire

### rtl/periodic_event_timer_table_core.sv
// Periodic event timer table: a row of NUM_SLOTS timer cells walked by a scan token.
// Tick: busy for the row scan and a drain state, one cell visited per cycle; each fired
// result is held until the next fire or the drain state, the final one marked last.
// Add: busy until a free cell is claimed or the row is full. Delete: no busy time.
// Results are single-cycle strobes. Reset empties every slot. Uses pet_pkg, pet_cell.
`default_nettype none

module periodic_event_timer_table_core #(
	parameter int NUM_SLOTS = pet_pkg::MAX_SLOTS
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire pet_pkg::item_t   item,
	output logic                  strobe,
	output pet_pkg::result_t      result
);

	localparam logic [pet_pkg::IDX_W-1:0] LAST_IDX = pet_pkg::IDX_W'(NUM_SLOTS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t                       state_q;
	logic [1:0]                   op_q;
	logic [pet_pkg::PERIOD_W-1:0] period_q;
	logic [pet_pkg::COUNT_W-1:0]  count_q;
	logic [pet_pkg::IDX_W-1:0]    idx_q;
	logic                         pend_v_q;
	logic [pet_pkg::IDX_W-1:0]    pend_idx_q;
	logic                         strobe_q;
	pet_pkg::result_t             result_q;

	pet_pkg::cell_cmd_t           ctl;
	logic [NUM_SLOTS-1:0]         tok;
	logic [NUM_SLOTS-1:0]         hits;
	logic                         accept;
	logic                         hit_any;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign hit_any = |hits;
	assign strobe  = strobe_q;
	assign result  = result_q;

	// Broadcast the held command to the row
	always_comb begin
		ctl.tick         = (state_q == ST_SCAN) && (op_q == pet_pkg::OP_TICK);
		ctl.add          = (state_q == ST_SCAN) && (op_q == pet_pkg::OP_ADD);
		ctl.period       = period_q;
		ctl.repeat_count = count_q;
	end

	// Row of cells; the token enters cell 0 on the first scan cycle
	for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
		logic tok_in;
		if (i == 0) begin : g_head
			assign tok_in = (state_q == ST_SCAN) && (idx_q == '0);
		end else begin : g_link
			assign tok_in = tok[i-1];
		end

		pet_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.tok_in  (tok_in),
			.del     (accept && (item.operation == pet_pkg::OP_DELETE)
			          && (item.slot == pet_pkg::IDX_W'(i))),
			.tok_out (tok[i]),
			.hit     (hits[i])
		);
	end

	// Sequence the scan and register each result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= pet_pkg::OP_TICK;
			period_q   <= '0;
			count_q    <= '0;
			idx_q      <= '0;
			pend_v_q   <= 1'b0;
			pend_idx_q <= '0;
			strobe_q   <= 1'b0;
			result_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					strobe_q <= 1'b0;
					if (accept) begin
						op_q     <= item.operation;
						period_q <= item.period;
						count_q  <= item.repeat_count;
						idx_q    <= '0;
						pend_v_q <= 1'b0;
						if (item.operation == pet_pkg::OP_TICK
						    || item.operation == pet_pkg::OP_ADD) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (op_q == pet_pkg::OP_ADD) begin
						strobe_q <= hit_any || (idx_q == LAST_IDX);
						if (hit_any) begin
							result_q.kind       <= pet_pkg::KIND_ADDED;
							result_q.slot_index <= idx_q;
							result_q.last       <= 1'b1;
							state_q             <= ST_IDLE;
						end else if (idx_q == LAST_IDX) begin
							result_q.kind       <= pet_pkg::KIND_FULL;
							result_q.slot_index <= '0;
							result_q.last       <= 1'b1;
							state_q             <= ST_IDLE;
						end
					end else begin
						// Release the previous fire once a later one shows up
						strobe_q <= hit_any && pend_v_q;
						if (hit_any) begin
							if (pend_v_q) begin
								result_q.kind       <= pet_pkg::KIND_FIRED;
								result_q.slot_index <= pend_idx_q;
								result_q.last       <= 1'b0;
							end
							pend_v_q   <= 1'b1;
							pend_idx_q <= idx_q;
						end
						if (idx_q == LAST_IDX) begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					// Flush the final fire of the tick marked last
					strobe_q <= pend_v_q;
					if (pend_v_q) begin
						result_q.kind       <= pet_pkg::KIND_FIRED;
						result_q.slot_index <= pend_idx_q;
						result_q.last       <= 1'b1;
					end
					pend_v_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: begin
					strobe_q <= 1'b0;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

### sim/tb_periodic_event_timer_table_core.sv
`timescale 1ns / 1ps
// Self-checking bench for periodic_event_timer_table_core: directed and random
// add, tick and delete beats against a slot-table shadow. Depends on pet_pkg and the core.

module tb_periodic_event_timer_table_core;

	import pet_pkg::*;

	localparam int SLOTS        = MAX_SLOTS;
	localparam int RANDOM_ITEMS = 180;
	localparam int DRAIN_CYCLES = 2 * SLOTS + 8;
	localparam int CYCLE_LIMIT  = 300000;

	// Operation code the block must ignore
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Shadow of the slot table and the results it still owes
	class timer_table_shadow;
		bit                  used      [SLOTS];
		logic [PERIOD_W-1:0] remaining [SLOTS];
		logic [PERIOD_W-1:0] reload    [SLOTS];
		logic [COUNT_W-1:0]  left      [SLOTS];
		bit                  limited   [SLOTS];
		result_t             due_results [$];

		function new();
			for (int i = 0; i < SLOTS; i++) begin
				used[i] = 0;
			end
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		// Apply one accepted beat and queue the results it causes
		function void take_item(item_t it);
			result_t res;
			int      fired;
			bit      done;
			case (it.operation)
				OP_ADD: begin
					res.kind       = KIND_FULL;
					res.slot_index = '0;
					res.last       = 1'b1;
					for (int i = 0; i < SLOTS; i++) begin
						if (!used[i]) begin
							used[i]        = 1;
							reload[i]      = it.period;
							left[i]        = it.repeat_count;
							limited[i]     = (it.repeat_count != 0);
							remaining[i]   = '0;
							res.kind       = KIND_ADDED;
							res.slot_index = i[IDX_W-1:0];
							break;
						end
					end
					due_results.push_back(res);
				end
				OP_DELETE: begin
					if (int'(it.slot) < SLOTS) used[it.slot] = 0;
				end
				OP_TICK: begin
					// count down, floor at zero
					for (int i = 0; i < SLOTS; i++) begin
						if (used[i] && remaining[i] != 0) remaining[i] = remaining[i] - 1'b1;
					end
					// fire due slots in ascending order
					fired = 0;
					for (int i = 0; i < SLOTS; i++) begin
						if (used[i] && remaining[i] == 0) begin
							res.kind       = KIND_FIRED;
							res.slot_index = i[IDX_W-1:0];
							res.last       = 1'b0;
							due_results.push_back(res);
							fired++;
							done = (reload[i] == 0);
							if (limited[i]) begin
								left[i] = left[i] - 1'b1;
								if (left[i] == 0) done = 1;
							end
							if (done) used[i] = 0;
							else remaining[i] = reload[i];
						end
					end
					// mark the final fire of this tick
					if (fired > 0) begin
						res      = due_results.pop_back();
						res.last = 1'b1;
						due_results.push_back(res);
					end
				end
				default: ;
			endcase
		endfunction

		// Compare a result beat with the oldest one owed
		function bit match_result(result_t got, output string why);
			result_t want;
			why = "";
			if (due_results.size() == 0) begin
				why = $sformatf("unexpected result kind %0d slot %0d last %0d",
					got.kind, got.slot_index, got.last);
				return 0;
			end
			want = due_results.pop_front();
			if (got.kind !== want.kind)
				why = {why, $sformatf(" kind got %0d want %0d", got.kind, want.kind)};
			if (got.slot_index !== want.slot_index)
				why = {why, $sformatf(" slot got %0d want %0d", got.slot_index,
					want.slot_index)};
			if (got.last !== want.last)
				why = {why, $sformatf(" last got %0d want %0d", got.last, want.last)};
			if (why != "") begin
				why = {"result differs:", why};
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item_in;
	logic    strobe;
	result_t result;

	timer_table_shadow shadow = new();
	int mismatch_count = 0;
	int cycle_count    = 0;

	periodic_event_timer_table_core #(
		.NUM_SLOTS(SLOTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item_in),
		.strobe (strobe),
		.result (result)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(string why);
		mismatch_count++;
		$display("mismatch at cycle %0d: %s", cycle_count, why);
	endtask

	// Note accepted beats before checking results of the same edge
	always @(posedge clk) begin
		string why;
		if (arst_n) begin
			if (start && !busy) shadow.take_item(item_in);
			if (strobe && !shadow.match_result(result, why)) report_mismatch(why);
		end
	end

	function automatic item_t beat(logic [1:0] op, logic [PERIOD_W-1:0] period,
		logic [COUNT_W-1:0] count, logic [IDX_W-1:0] slot);
		item_t it;
		it.operation    = op;
		it.period       = period;
		it.repeat_count = count;
		it.slot         = slot;
		return it;
	endfunction

	// Present one beat and hold it until accepted; start stays high afterwards
	task automatic send_beat(item_t it);
		@(negedge clk);
		start   <= 1'b1;
		item_in <= it;
		do @(posedge clk); while (busy);
	endtask

	task automatic pause(int n);
		repeat (n) @(negedge clk) start <= 1'b0;
	endtask

	// Bound the run
	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
		$display("tb_periodic_event_timer_table_core: done, errors");
		$finish;
	end

	initial begin
		item_t it;
		int    sent;
		int    burst;
		int    pick;

		arst_n  = 1'b0;
		start   = 1'b0;
		item_in = '0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		pause(2);

		// Directed: fire-once, every-tick, limited and extreme slots, then fill
		send_beat(beat(OP_ADD, '0, '0, '0));
		send_beat(beat(OP_ADD, 24'd1, '0, '0));
		send_beat(beat(OP_ADD, 24'd3, 16'd2, '0));
		send_beat(beat(OP_ADD, 24'hFFFFFF, 16'hFFFF, 4'hF));
		for (int i = 0; i < SLOTS - 4; i++)
			send_beat(beat(OP_ADD, PERIOD_W'($urandom_range(1, 6)),
				COUNT_W'($urandom_range(1, 3)), '0));
		// table full
		send_beat(beat(OP_ADD, 24'd2, 16'd1, '0));
		pause(3);
		repeat (3) send_beat(beat(OP_TICK, '0, '0, '0));
		// delete slot 15 (used unless it has run out), then the same slot once free, then an ignored code
		send_beat(beat(OP_DELETE, '0, '0, 4'hF));
		send_beat(beat(OP_DELETE, '0, '0, 4'hF));
		send_beat(beat(OP_UNUSED, 24'hFFFFFF, 16'hFFFF, 4'hF));
		send_beat(beat(OP_TICK, '0, '0, '0));
		pause(5);

		// Random bursts with random gaps
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				pick = $urandom_range(0, 99);
				it.operation = (pick < 45) ? OP_TICK :
					(pick < 78) ? OP_ADD :
					(pick < 97) ? OP_DELETE : OP_UNUSED;
				pick = $urandom_range(0, 99);
				it.period = (pick < 60) ? PERIOD_W'($urandom_range(0, 4)) :
					(pick < 85) ? PERIOD_W'($urandom_range(5, 20)) : PERIOD_W'($urandom);
				pick = $urandom_range(0, 99);
				it.repeat_count = (pick < 40) ? '0 :
					(pick < 80) ? COUNT_W'($urandom_range(1, 4)) :
					COUNT_W'($urandom_range(0, 65535));
				it.slot = IDX_W'($urandom_range(0, SLOTS - 1));
				send_beat(it);
				if (it.operation != OP_UNUSED) sent++;
			end
			pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
		end

		// Drain and finish
		@(negedge clk) start <= 1'b0;
		while (shadow.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_periodic_event_timer_table_core: done, clean");
		else
			$display("tb_periodic_event_timer_table_core: done, errors");
		$finish;
	end

endmodule

### filelist.f
rtl/pet_pkg.sv
rtl/pet_cell.sv
rtl/periodic_event_timer_table_core.sv
sim/tb_periodic_event_timer_table_core.sv
